/* rtl/bpf_pkg.sv */
// Package for the biosignal packet framer: beat types, frame sizes and helpers.
// Used by every module of the framer and by its checker; depends on nothing.
package bpf_pkg;

    // Frame geometry.
    localparam int SAMPLES_PER_FRAME = 7;
    localparam int ECG_BITS          = 12;
    localparam int OPT_BITS          = 18;
    localparam int WORD_BITS         = 32;
    localparam int BODY_BYTES        = 2 * SAMPLES_PER_FRAME + 8;
    localparam int BODY_BITS         = 8 * BODY_BYTES;
    localparam int FRAME_LEN         = BODY_BYTES + 3;
    localparam int COUNT_BITS        = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;
    localparam int BODY_CNT_BITS     = $clog2(BODY_BYTES);
    localparam int BEAT_CNT_BITS     = $clog2(FRAME_LEN);

    localparam logic [ECG_BITS-1:0] ECG_RESET = ECG_BITS'(2048);

    // Input kinds.
    localparam logic KIND_ECG     = 1'b0;
    localparam logic KIND_OPTICAL = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEADER_FIRST  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEADER_SECOND = 1'b1;
    localparam logic [7:0] HEADER_FIRST_RESET  = 8'd170;
    localparam logic [7:0] HEADER_SECOND_RESET = 8'd85;

    typedef struct packed {
        logic        kind;
        logic [11:0] ecg_sample;
        logic        lead_off_minus;
        logic        lead_off_plus;
        logic [23:0] red_raw;
        logic [23:0] ir_raw;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_out_beat;

    // Everything one frame needs besides the headers.
    typedef struct packed {
        logic [SAMPLES_PER_FRAME-1:0][ECG_BITS-1:0] ecg;
        logic [OPT_BITS-1:0]                        red;
        logic [OPT_BITS-1:0]                        ir;
    } t_frame;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
    } t_header;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HEAD0,
        BK_HEAD1,
        BK_BODY,
        BK_SUM
    } t_bk_state;

    // Lays a frame out as its body bytes, first byte in the top bits.
    function automatic logic [BODY_BITS-1:0] frame_body(input t_frame f);
        logic [BODY_BITS-1:0] body;
        body = '0;
        for (int i = 0; i < SAMPLES_PER_FRAME; i++) begin
            body[BODY_BITS-1-16*i -: 16] = 16'(f.ecg[i]);
        end
        body[63:32] = WORD_BITS'(f.red);
        body[31:0]  = WORD_BITS'(f.ir);
        return body;
    endfunction

endpackage

/* rtl/bpf_queue.sv */
// Two-entry frame queue between the framer's front and back parts.
// Depends on bpf_pkg for the frame descriptor and status types.
module bpf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bpf_pkg::t_frame     i_push_data,
    input  logic                i_pop,
    output bpf_pkg::t_frame     o_pop_data,
    output bpf_pkg::t_q_status  o_status
);

    bpf_pkg::t_frame r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    // Pointer and fill bookkeeping; the caller never pushes when full or pops when empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data     = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = (r_count == 2'd2);

endmodule

/* rtl/bpf_front.sv */
// Front part of the framer: accepts input beats, keeps the ECG and optical state
// and hands each complete frame to the queue. Depends on bpf_pkg.
module bpf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bpf_pkg::t_in_beat   i_in,
    input  bpf_pkg::t_q_status  i_q_status,
    output logic                o_push,
    output bpf_pkg::t_frame     o_push_data
);

    logic [bpf_pkg::ECG_BITS-1:0]   r_store [bpf_pkg::SAMPLES_PER_FRAME];
    logic [bpf_pkg::COUNT_BITS-1:0] r_count;
    logic [bpf_pkg::ECG_BITS-1:0]   r_last_good;
    logic [bpf_pkg::OPT_BITS-1:0]   r_red;
    logic [bpf_pkg::OPT_BITS-1:0]   r_ir;
    logic                           r_pending;

    logic                           accept;
    logic                           ecg_beat;
    logic                           frame_done;
    logic [bpf_pkg::ECG_BITS-1:0]   n_last_good;

    // A beat is taken whenever the queue has room for a frame it might complete.
    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign ecg_beat   = accept && (i_in.kind == bpf_pkg::KIND_ECG);
    assign frame_done = ecg_beat
                        && (r_count == bpf_pkg::COUNT_BITS'(bpf_pkg::SAMPLES_PER_FRAME - 1));

    // A detached lead repeats the last good reading.
    always_comb begin
        if (i_in.lead_off_minus || i_in.lead_off_plus) begin
            n_last_good = r_last_good;
        end else begin
            n_last_good = bpf_pkg::ECG_BITS'(i_in.ecg_sample);
        end
    end

    // Frame snapshot: stored samples plus the one arriving now in the last slot; optical or zero.
    always_comb begin
        for (int i = 0; i < bpf_pkg::SAMPLES_PER_FRAME; i++) begin
            if (i == bpf_pkg::SAMPLES_PER_FRAME - 1) begin
                o_push_data.ecg[i] = n_last_good;
            end else begin
                o_push_data.ecg[i] = r_store[i];
            end
        end
        o_push_data.red = r_pending ? r_red : '0;
        o_push_data.ir  = r_pending ? r_ir  : '0;
    end

    assign o_push = frame_done;

    // Control and sample state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last_good <= bpf_pkg::ECG_RESET;
            r_red       <= '0;
            r_ir        <= '0;
            r_pending   <= 1'b0;
        end else if (accept) begin
            if (i_in.kind == bpf_pkg::KIND_OPTICAL) begin
                r_red     <= i_in.red_raw[bpf_pkg::OPT_BITS-1:0];
                r_ir      <= i_in.ir_raw[bpf_pkg::OPT_BITS-1:0];
                r_pending <= 1'b1;
            end else begin
                r_last_good <= n_last_good;
                if (frame_done) begin
                    r_count   <= '0;
                    r_pending <= 1'b0;
                end else begin
                    r_count <= r_count + bpf_pkg::COUNT_BITS'(1);
                end
            end
        end
    end

    // Sample store, written once per ECG beat.
    always_ff @(posedge i_clk) begin
        if (ecg_beat) begin
            r_store[r_count] <= n_last_good;
        end
    end

endmodule

/* rtl/bpf_back.sv */
// Back part of the framer: pops frames from the queue and sends them a byte per
// beat through an output register, adding headers and checksum. Depends on bpf_pkg.
module bpf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bpf_pkg::t_header    i_header,
    input  bpf_pkg::t_q_status  i_q_status,
    input  bpf_pkg::t_frame     i_pop_data,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bpf_pkg::t_out_beat  o_out
);

    bpf_pkg::t_bk_state                r_state;
    bpf_pkg::t_bk_state                n_state;
    logic [bpf_pkg::BODY_BITS-1:0]     r_body;
    logic [bpf_pkg::BODY_CNT_BITS-1:0] r_cnt;
    logic [7:0]                        r_sum;
    bpf_pkg::t_out_beat                r_out;
    logic                              r_out_valid;

    logic                              adv;
    logic                              emit;
    logic                              body_end;
    bpf_pkg::t_out_beat                beat;

    // The output register can take a new beat when empty or being drained.
    assign adv      = !r_out_valid || i_out_ready;
    assign body_end = (r_cnt == bpf_pkg::BODY_CNT_BITS'(bpf_pkg::BODY_BYTES - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bpf_pkg::BK_IDLE: begin
                if (!i_q_status.empty) n_state = bpf_pkg::BK_HEAD0;
            end
            bpf_pkg::BK_HEAD0: begin
                if (adv) n_state = bpf_pkg::BK_HEAD1;
            end
            bpf_pkg::BK_HEAD1: begin
                if (adv) n_state = bpf_pkg::BK_BODY;
            end
            bpf_pkg::BK_BODY: begin
                if (adv && body_end) n_state = bpf_pkg::BK_SUM;
            end
            bpf_pkg::BK_SUM: begin
                if (adv) begin
                    n_state = i_q_status.empty ? bpf_pkg::BK_IDLE : bpf_pkg::BK_HEAD0;
                end
            end
            default: n_state = bpf_pkg::BK_IDLE;
        endcase
    end

    // Outputs of the sequencer: queue pop, beat emission and beat contents.
    always_comb begin
        o_pop = 1'b0;
        emit  = 1'b0;
        beat  = '0;
        case (r_state)
            bpf_pkg::BK_IDLE: begin
                o_pop = !i_q_status.empty;
            end
            bpf_pkg::BK_HEAD0: begin
                emit            = adv;
                beat.frame_byte = i_header.first;
            end
            bpf_pkg::BK_HEAD1: begin
                emit            = adv;
                beat.frame_byte = i_header.second;
            end
            bpf_pkg::BK_BODY: begin
                emit            = adv;
                beat.frame_byte = r_body[bpf_pkg::BODY_BITS-1 -: 8];
            end
            bpf_pkg::BK_SUM: begin
                emit            = adv;
                o_pop           = adv && !i_q_status.empty;
                beat.frame_byte = r_sum;
                beat.frame_last = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Sequencer state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpf_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_out_valid <= emit;
            end
        end
    end

    // Body shifter, byte counter, running checksum and output payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_body <= bpf_pkg::frame_body(i_pop_data);
        end else if (emit && (r_state == bpf_pkg::BK_BODY)) begin
            r_body <= {r_body[bpf_pkg::BODY_BITS-9:0], 8'h00};
        end
        if (emit && (r_state == bpf_pkg::BK_HEAD1)) begin
            r_cnt <= '0;
            r_sum <= 8'h00;
        end else if (emit && (r_state == bpf_pkg::BK_BODY)) begin
            r_cnt <= r_cnt + bpf_pkg::BODY_CNT_BITS'(1);
            r_sum <= r_sum + beat.frame_byte;
        end
        if (adv) begin
            r_out <= beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/biosignal_packet_framer.sv */
// Top level of the biosignal packet framer: header registers, front, queue, back.
// Depends on bpf_pkg, bpf_front, bpf_queue and bpf_back.
//
//  Channel   Handshake                    Payload
//  input     i_in_valid / o_in_ready      i_in  (bpf_pkg::t_in_beat)
//  output    o_out_valid / i_out_ready    o_out (bpf_pkg::t_out_beat)
//  config    i_cfg_we                     i_cfg_index, i_cfg_data
//
// Input beats are taken one per cycle while the two-entry frame queue has room.
// Each frame leaves as 25 beats, without gaps while the sink is ready, so the byte
// serializer, not the input side, limits the sustained rate of ECG beats.
// Reset is synchronous and active low; the sample store needs no clearing.
// A stalled sink holds the output register; the queue then fills and stalls the input.
module biosignal_packet_framer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  bpf_pkg::t_in_beat                    i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output bpf_pkg::t_out_beat                   o_out,
    input  logic                                 i_cfg_we,
    input  logic [bpf_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [7:0]                           i_cfg_data
);

    bpf_pkg::t_header   r_header;
    bpf_pkg::t_q_status q_status;
    bpf_pkg::t_frame    push_data;
    bpf_pkg::t_frame    pop_data;
    logic               push;
    logic               pop;

    // Header registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header.first  <= bpf_pkg::HEADER_FIRST_RESET;
            r_header.second <= bpf_pkg::HEADER_SECOND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bpf_pkg::REG_HEADER_FIRST:  r_header.first  <= i_cfg_data;
                bpf_pkg::REG_HEADER_SECOND: r_header.second <= i_cfg_data;
                default:                    r_header <= r_header;
            endcase
        end
    end

    bpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    bpf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    bpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_header    (r_header),
        .i_q_status  (q_status),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* rtl/bpf_checker.sv */
// Port-level checker for the biosignal packet framer, bound to the top level.
// Depends on bpf_pkg for the beat type and frame length.
module bpf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input bpf_pkg::t_out_beat o_out
);

    logic [bpf_pkg::BEAT_CNT_BITS-1:0] r_beat;
    logic                              out_accept;

    assign out_accept = o_out_valid && i_out_ready;

    // Position of the next output beat within its frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else if (out_accept) begin
            if (o_out.frame_last) begin
                r_beat <= '0;
            end else begin
                r_beat <= r_beat + bpf_pkg::BEAT_CNT_BITS'(1);
            end
        end
    end

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // The last flag marks exactly the final beat of each frame.
    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept |-> (o_out.frame_last
                        == (r_beat == bpf_pkg::BEAT_CNT_BITS'(bpf_pkg::FRAME_LEN - 1))))
        else $error("frame_last out of place");

    // A stalled beat stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled beat keeps its payload.
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("output payload changed while stalled");

endmodule

bind biosignal_packet_framer bpf_checker u_bpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
